### rtl/bvo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bvo_pkg
// Shared types and constants of the bounding-box tree overlap query block.
// ----------------------------------------------------------------------------
package bvo_pkg;

    localparam int NODE_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(NODE_DEPTH);
    localparam int COORD_BITS = 16;
    localparam int LINK_W     = 16;
    localparam int CNT_W      = 11;
    localparam int IDS_W      = 6;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 1;
    // walk index must hold the last node plus the widest escape skip
    localparam int WALK_W     = ((ADDR_W > LINK_W) ? ADDR_W : LINK_W) + 1;
    // coordinate difference, possibly negated
    localparam int DIFF_W     = COORD_BITS + 2;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int RESQ_DEPTH = 4;
    localparam int RESQ_AW    = $clog2(RESQ_DEPTH);

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_RECT  = 2'd1,
        REQ_SEG   = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_COUNT = 1'b0,
        CFG_MAX_IDS    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_req                         req;
        logic [ADDR_W-1:0]            addr;
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [LINK_W-1:0]     link;
    } t_cmd;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] lo_x;
        logic signed [COORD_BITS-1:0] lo_y;
        logic signed [COORD_BITS-1:0] hi_x;
        logic signed [COORD_BITS-1:0] hi_y;
        logic signed [LINK_W-1:0]     link;
    } t_node;

    typedef struct packed {
        logic [ADDR_W-1:0] chunk_index;
        logic              is_summary;
        logic [IDS_W-1:0]  hit_count;
        logic [CNT_W-1:0]  overlap_total;
        logic              last;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_MUL,
        S_CMP,
        S_EMIT,
        S_SUM
    } t_walk_state;

endpackage
`default_nettype wire

### rtl/bvo_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bvo_front
// Accepts request beats, drops unknown request codes and queues the rest
// for the walk engine.
// ----------------------------------------------------------------------------
module bvo_front
    import bvo_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic push,
    output logic      full,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_valid,
    output t_cmd      o_cmd,
    input  wire logic i_cmd_pop
);

    t_cmd               r_q [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wp;
    logic [CMDQ_AW-1:0] r_rp;
    logic [CMDQ_AW:0]   r_cnt;
    logic               w_acc;
    logic               w_keep;
    logic               w_pop;

    // classify: only writes and the two query kinds go on
    assign w_keep      = (i_cmd.req != REQ_NONE);
    assign full        = (r_cnt == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign w_acc       = push && !full && w_keep;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    // store beat
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_acc) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (CMDQ_AW+1)'(w_acc) - (CMDQ_AW+1)'(w_pop);
        end
    end

endmodule
`default_nettype wire

### rtl/bvo_resq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bvo_resq
// Result queue between the walk engine and the result port.
// ----------------------------------------------------------------------------
module bvo_resq
    import bvo_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_res i_res,
    output logic      o_full,
    output logic      empty,
    output t_res      o_res,
    input  wire logic pop
);

    t_res               r_q [RESQ_DEPTH];
    logic [RESQ_AW-1:0] r_wp;
    logic [RESQ_AW-1:0] r_rp;
    logic [RESQ_AW:0]   r_cnt;
    logic               w_acc;
    logic               w_pop;

    assign o_full = (r_cnt == (RESQ_AW+1)'(RESQ_DEPTH));
    assign empty  = (r_cnt == '0);
    assign o_res  = r_q[r_rp];
    assign w_acc  = i_push && !o_full;
    assign w_pop  = pop && !empty;

    // store beat
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q[r_wp] <= i_res;
        end
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_acc) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (RESQ_AW+1)'(w_acc) - (RESQ_AW+1)'(w_pop);
        end
    end

endmodule
`default_nettype wire

### rtl/bvo_walk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bvo_walk
// Node table and traversal engine: performs node writes, walks the table
// for queries with escape skips, and pushes hit and summary beats.
// ----------------------------------------------------------------------------
module bvo_walk
    import bvo_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CNT_W-1:0]  i_cfg_data,
    input  wire logic              i_cmd_valid,
    input  wire t_cmd              i_cmd,
    output logic                   o_cmd_pop,
    output logic                   o_res_push,
    output t_res                   o_res,
    input  wire logic              i_res_full
);

    t_walk_state r_state, n_state;

    t_node r_mem [NODE_DEPTH];
    t_node r_rd;

    logic [CNT_W-1:0]  r_node_count;
    logic [IDS_W-1:0]  r_max_ids;

    // query context
    logic                         r_seg;
    logic signed [COORD_BITS-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [DIFF_W-1:0]     r_dx, r_dy;
    logic                         r_negx, r_negy, r_parx, r_pary;
    logic [WALK_W-1:0]            r_i;
    logic [CNT_W-1:0]             r_limit;
    logic [IDS_W-1:0]             r_n;
    logic [CNT_W-1:0]             r_total;
    logic [ADDR_W-1:0]            r_emit_idx;

    // segment test stages
    logic signed [DIFF_W-1:0] r_n1x, r_n2x, r_n1y, r_n2y;
    logic                     r_slab_ok;
    logic signed [PROD_W-1:0] r_p1, r_p2, r_p3, r_p4;

    logic w_start, w_write, w_decide, w_hit, w_leaf, w_rect_hit, w_seg_hit;
    logic w_emit;
    logic signed [COORD_BITS:0] w_dx_s, w_dy_s;
    logic signed [DIFF_W-1:0]   w_n1x, w_n2x, w_n1y, w_n2y;
    logic signed [DIFF_W-1:0]   w_a1x, w_a2x, w_a1y, w_a2y;
    logic                       w_outx, w_outy;
    logic [WALK_W-1:0]          w_skip;

    // ---------------- command decode ----------------
    assign w_write = (r_state == S_IDLE) && i_cmd_valid && (i_cmd.req == REQ_WRITE);
    assign w_start = (r_state == S_IDLE) && i_cmd_valid && (i_cmd.req != REQ_WRITE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
            r_max_ids    <= IDS_W'(63);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NODE_COUNT: r_node_count <= i_cfg_data;
                CFG_MAX_IDS:    r_max_ids    <= i_cfg_data[IDS_W-1:0];
                default: ;
            endcase
        end
    end

    // node table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_mem[i_cmd.addr] <= '{lo_x: i_cmd.ax, lo_y: i_cmd.ay,
                                   hi_x: i_cmd.bx, hi_y: i_cmd.by,
                                   link: i_cmd.link};
        end
        r_rd <= r_mem[r_i[ADDR_W-1:0]];
    end

    // segment deltas of the incoming query
    assign w_dx_s = $signed({i_cmd.bx[COORD_BITS-1], i_cmd.bx})
                  - $signed({i_cmd.ax[COORD_BITS-1], i_cmd.ax});
    assign w_dy_s = $signed({i_cmd.by[COORD_BITS-1], i_cmd.by})
                  - $signed({i_cmd.ay[COORD_BITS-1], i_cmd.ay});

    // ---------------- node tests ----------------
    // inclusive rectangle overlap
    assign w_rect_hit = !($signed(r_ax) > $signed(r_rd.hi_x) || $signed(r_bx) < $signed(r_rd.lo_x)
                       || $signed(r_ay) > $signed(r_rd.hi_y) || $signed(r_by) < $signed(r_rd.lo_y));

    // slab offsets, oriented along the segment direction
    always_comb begin
        w_a1x = DIFF_W'($signed(r_rd.lo_x)) - DIFF_W'($signed(r_ax));
        w_a2x = DIFF_W'($signed(r_rd.hi_x)) - DIFF_W'($signed(r_ax));
        w_a1y = DIFF_W'($signed(r_rd.lo_y)) - DIFF_W'($signed(r_ay));
        w_a2y = DIFF_W'($signed(r_rd.hi_y)) - DIFF_W'($signed(r_ay));
        if (r_negx) begin
            w_a1x = -w_a1x;
            w_a2x = -w_a2x;
        end
        if (r_negy) begin
            w_a1y = -w_a1y;
            w_a2y = -w_a2y;
        end
        w_n1x = (w_a1x > w_a2x) ? w_a2x : w_a1x;
        w_n2x = (w_a1x > w_a2x) ? w_a1x : w_a2x;
        w_n1y = (w_a1y > w_a2y) ? w_a2y : w_a1y;
        w_n2y = (w_a1y > w_a2y) ? w_a1y : w_a2y;
    end

    assign w_outx = $signed(r_ax) < $signed(r_rd.lo_x) || $signed(r_ax) > $signed(r_rd.hi_x);
    assign w_outy = $signed(r_ay) < $signed(r_rd.lo_y) || $signed(r_ay) > $signed(r_rd.hi_y);

    // every entry bound must lie at or below every exit bound
    assign w_seg_hit = r_slab_ok
                    && (r_parx || (r_n1x <= r_dx && r_n2x >= 0))
                    && (r_pary || (r_n1y <= r_dy && r_n2y >= 0))
                    && (r_parx || r_pary || (r_p1 <= r_p2 && r_p3 <= r_p4));

    assign w_decide = (r_state == S_CMP) || (r_state == S_EVAL && !r_seg);
    assign w_hit    = r_seg ? w_seg_hit : w_rect_hit;
    assign w_leaf   = !r_rd.link[LINK_W-1];
    assign w_emit   = w_decide && w_hit && w_leaf && (r_n < r_max_ids);
    assign w_skip   = -WALK_W'($signed(r_rd.link));

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_start) n_state = S_READ;
            S_READ: n_state = (r_i < WALK_W'(r_limit)) ? S_EVAL : S_SUM;
            S_EVAL: begin
                if (r_seg) n_state = S_MUL;
                else       n_state = w_emit ? S_EMIT : S_READ;
            end
            S_MUL:  n_state = S_CMP;
            S_CMP:  n_state = w_emit ? S_EMIT : S_READ;
            S_EMIT: if (!i_res_full) n_state = S_READ;
            S_SUM:  if (!i_res_full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- outputs ----------------
    always_comb begin
        o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid;
        o_res_push = 1'b0;
        o_res      = '0;
        unique case (r_state)
            S_EMIT: begin
                o_res_push        = !i_res_full;
                o_res.chunk_index = r_emit_idx;
            end
            S_SUM: begin
                o_res_push          = !i_res_full;
                o_res.is_summary    = 1'b1;
                o_res.hit_count     = r_n;
                o_res.overlap_total = r_seg ? '0 : r_total;
                o_res.last          = 1'b1;
            end
            default: ;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // walk counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i     <= '0;
            r_n     <= '0;
            r_total <= '0;
        end else if (w_start) begin
            r_i     <= '0;
            r_n     <= '0;
            r_total <= '0;
        end else if (w_decide) begin
            r_i <= (w_hit || w_leaf) ? r_i + 1'b1 : r_i + w_skip;
            if (w_hit && w_leaf) begin
                r_total <= r_total + 1'b1;
            end
            if (w_emit) begin
                r_n <= r_n + 1'b1;
            end
        end
    end

    // query context and test stages
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_seg   <= (i_cmd.req == REQ_SEG);
            r_ax    <= i_cmd.ax;
            r_ay    <= i_cmd.ay;
            r_bx    <= i_cmd.bx;
            r_by    <= i_cmd.by;
            r_negx  <= w_dx_s[COORD_BITS];
            r_negy  <= w_dy_s[COORD_BITS];
            r_parx  <= (w_dx_s == '0);
            r_pary  <= (w_dy_s == '0);
            r_dx    <= w_dx_s[COORD_BITS] ? -DIFF_W'(w_dx_s) : DIFF_W'(w_dx_s);
            r_dy    <= w_dy_s[COORD_BITS] ? -DIFF_W'(w_dy_s) : DIFF_W'(w_dy_s);
            r_limit <= (r_node_count > CNT_W'(NODE_DEPTH)) ? CNT_W'(NODE_DEPTH)
                                                           : r_node_count;
        end
        if (r_state == S_EVAL) begin
            r_n1x     <= w_n1x;
            r_n2x     <= w_n2x;
            r_n1y     <= w_n1y;
            r_n2y     <= w_n2y;
            r_slab_ok <= !(r_parx && w_outx) && !(r_pary && w_outy);
        end
        if (r_state == S_MUL) begin
            r_p1 <= PROD_W'(r_n1x) * PROD_W'(r_dy);
            r_p2 <= PROD_W'(r_n2y) * PROD_W'(r_dx);
            r_p3 <= PROD_W'(r_n1y) * PROD_W'(r_dx);
            r_p4 <= PROD_W'(r_n2x) * PROD_W'(r_dy);
        end
        if (w_emit) begin
            r_emit_idx <= r_i[ADDR_W-1:0];
        end
    end

    // ---------------- checks ----------------
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full) else $error("result pushed into full queue");

    a_emit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_n != '0)) else $error("hit beat without count");

    a_total_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_total >= CNT_W'(r_n)))
        else $error("emitted hits exceed overlap total");

endmodule
`default_nettype wire

### rtl/bvh_overlap_query.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bvh_overlap_query
// Overlap query engine over a flattened 2D bounding-box tree.
//
// Requests enter through push/full; a beat is taken when push is high and
// full is low. A node write stores one box and link; rectangle and segment
// queries walk nodes 0 to min(node_count, 1024)-1 with escape skips.
// Results leave through empty/pop: one beat per emitted leaf, then a summary
// beat with last set. Config writes (i_cfg_we) take effect at once; the user
// must make them only while idle, the block does not enforce it. A query
// visits each node through read and test states (read, offset, multiply,
// compare for segments; read and test for rectangles), with an emit state
// per emitted leaf, then a final index check and the summary. Front and walk
// engine run apart through a two-entry request queue, so a new request is
// taken while a query is walking and the queue has room. A stalled result
// port fills the four-entry result queue and then halts the walk. Reset
// empties both queues and restores node_count 0 and max_ids 63; the node
// table is not cleared and must be written first.
// ----------------------------------------------------------------------------
module bvh_overlap_query
    import bvo_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [REQ_W-1:0]      i_req_type,
    input  wire logic [ADDR_W-1:0]     i_node_addr,
    input  wire logic signed [COORD_BITS-1:0] i_box_min_x,
    input  wire logic signed [COORD_BITS-1:0] i_box_min_y,
    input  wire logic signed [COORD_BITS-1:0] i_box_max_x,
    input  wire logic signed [COORD_BITS-1:0] i_box_max_y,
    input  wire logic signed [LINK_W-1:0]     i_node_link,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [ADDR_W-1:0]          o_chunk_index,
    output logic                       o_is_summary,
    output logic [IDS_W-1:0]           o_hit_count,
    output logic [CNT_W-1:0]           o_overlap_total,
    output logic                       o_last,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CNT_W-1:0]      i_cfg_data
);

    t_cmd w_in_cmd, w_cmd;
    t_res w_res_in, w_res_out;
    logic w_cmd_valid, w_cmd_pop, w_res_push, w_res_full;

    // pack request beat
    assign w_in_cmd = '{req: t_req'(i_req_type), addr: i_node_addr,
                        ax: i_box_min_x, ay: i_box_min_y,
                        bx: i_box_max_x, by: i_box_max_y, link: i_node_link};

    bvo_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_cmd       (w_in_cmd),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    bvo_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in),
        .i_res_full  (w_res_full)
    );

    bvo_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res_in),
        .o_full  (w_res_full),
        .empty   (empty),
        .o_res   (w_res_out),
        .pop     (pop)
    );

    // unpack result beat
    assign o_chunk_index   = w_res_out.chunk_index;
    assign o_is_summary    = w_res_out.is_summary;
    assign o_hit_count     = w_res_out.hit_count;
    assign o_overlap_total = w_res_out.overlap_total;
    assign o_last          = w_res_out.last;

endmodule
`default_nettype wire
